>>> rtl/tsq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared sizes, codes and command/status types for the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int VALUE_W    = 32;
   localparam int OCC_W      = 7;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam logic REQ_ENQ = 1'b0;
   localparam logic REQ_DEQ = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOVE,
      S_POP
   } state_type;

   typedef struct packed {
      logic       push;
      logic       load_imm;
      status_type imm_status;
      logic       mv_read;
      logic       pop_read;
      logic       load_pop;
   } cmd_type;

   typedef struct packed {
      logic in_empty;
      logic out_empty;
      logic q_empty;
      logic q_full;
      logic mv_pending;
   } stat_type;

   function automatic logic [OCC_W-1:0] occ_of(logic [CNT_W-1:0] a,
                                                logic [CNT_W-1:0] b,
                                                logic             inc);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b} + {{CNT_W{1'b0}}, inc};
      return OCC_W'(s);
   endfunction

endpackage

>>> rtl/tsq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_datapath
// Input and output stack memories, element counters and result registers.
// ----------------------------------------------------------------------------
module tsq_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tsq_pkg::cmd_type                       cmd,
   input  logic signed [tsq_pkg::VALUE_W-1:0]     req_value_in,
   output tsq_pkg::stat_type                      stat,
   output logic signed [tsq_pkg::VALUE_W-1:0]     rsp_value_out,
   output logic [1:0]                             rsp_status,
   output logic [tsq_pkg::OCC_W-1:0]              rsp_occupancy
);
   import tsq_pkg::*;

   logic [DATA_WIDTH-1:0] in_mem  [DEPTH];
   logic [DATA_WIDTH-1:0] out_mem [DEPTH];

   logic [CNT_W-1:0]      in_count_ff, in_count_in;
   logic [CNT_W-1:0]      out_count_ff, out_count_in;
   logic [DATA_WIDTH-1:0] in_rdata_ff;
   logic [DATA_WIDTH-1:0] out_rdata_ff;
   logic                  mv_valid_ff;
   logic [ADDR_W-1:0]     in_top, out_top;
   logic [CNT_W:0]        total;

   logic [VALUE_W-1:0]    value_ff;
   status_type            status_ff;
   logic [OCC_W-1:0]      occ_ff;

   assign in_top = ADDR_W'(in_count_ff - 1'b1);
   assign out_top = ADDR_W'(out_count_ff - 1'b1);
   assign total = {1'b0, in_count_ff} + {1'b0, out_count_ff};

   assign stat.in_empty   = (in_count_ff == '0);
   assign stat.out_empty  = (out_count_ff == '0);
   assign stat.q_empty    = (total == '0);
   assign stat.q_full     = (total >= (CNT_W + 1)'(DEPTH));
   assign stat.mv_pending = mv_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         in_mem[in_count_ff[ADDR_W-1:0]] <= DATA_WIDTH'($unsigned(req_value_in));
      end
      if (cmd.mv_read) begin
         in_rdata_ff <= in_mem[in_top];
      end
   end

   always_ff @(posedge clock) begin
      if (mv_valid_ff) begin
         out_mem[out_count_ff[ADDR_W-1:0]] <= in_rdata_ff;
      end
      if (cmd.pop_read) begin
         out_rdata_ff <= out_mem[out_top];
      end
   end

   always_comb begin
      in_count_in = in_count_ff;
      if (cmd.push) begin
         in_count_in = in_count_ff + 1'b1;
      end else if (cmd.mv_read) begin
         in_count_in = in_count_ff - 1'b1;
      end
      out_count_in = out_count_ff;
      if (mv_valid_ff) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (cmd.pop_read) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         mv_valid_ff  <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         mv_valid_ff  <= cmd.mv_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_imm) begin
         value_ff  <= '0;
         status_ff <= cmd.imm_status;
         occ_ff    <= occ_of(in_count_ff, out_count_ff, cmd.push);
      end else if (cmd.load_pop) begin
         value_ff  <= VALUE_W'(out_rdata_ff);
         status_ff <= ST_OK;
         occ_ff    <= occ_of(in_count_ff, out_count_ff, 1'b0);
      end
   end

   assign rsp_value_out = value_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ff;

endmodule

>>> rtl/tsq_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_control
// Request sequencer: immediate answers, stack move and pop, result valid.
// ----------------------------------------------------------------------------
module tsq_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tsq_pkg::stat_type stat,
   output tsq_pkg::cmd_type  cmd
);
   import tsq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.imm_status = ST_OK;
      req_ready      = 1'b0;
      accept         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            accept    = req_valid && req_ready;
            if (accept) begin
               if (req_type == REQ_ENQ) begin
                  cmd.load_imm   = 1'b1;
                  cmd.push       = !stat.q_full;
                  cmd.imm_status = stat.q_full ? ST_FULL : ST_OK;
               end else if (stat.q_empty) begin
                  cmd.load_imm   = 1'b1;
                  cmd.imm_status = ST_EMPTY;
               end else if (stat.out_empty) begin
                  state_in = S_MOVE;
               end else begin
                  cmd.pop_read = 1'b1;
                  state_in     = S_POP;
               end
            end
         end
         S_MOVE: begin
            if (!stat.in_empty) begin
               cmd.mv_read = 1'b1;
            end else if (!stat.mv_pending) begin
               cmd.pop_read = 1'b1;
               state_in     = S_POP;
            end
         end
         S_POP: begin
            cmd.load_pop = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.load_imm || cmd.load_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/two_stack_fifo_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_fifo_queue
// Enqueue and error results load the result register at the transfer; a
// direct pop first reads the output stack top. A dequeue on an empty output
// stack first moves n input elements at one per cycle via the input read port.
// A new request is taken in idle once the result register is free or drains.
// Reset clears both counts, move flag, state and result valid; memories are not.
// ----------------------------------------------------------------------------
module two_stack_fifo_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic signed [tsq_pkg::VALUE_W-1:0] req_value_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tsq_pkg::VALUE_W-1:0] rsp_value_out,
   output logic [1:0]                         rsp_status,
   output logic [tsq_pkg::OCC_W-1:0]          rsp_occupancy
);
   import tsq_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tsq_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tsq_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_value_in  (req_value_in),
      .stat          (stat),
      .rsp_value_out (rsp_value_out),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= OCC_W'(DEPTH)))
      else $error("occupancy above depth");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value_out == '0))
      else $error("nonzero value on error status");

   a_enq_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == REQ_ENQ) |=>
      (rsp_valid && (rsp_status == ST_OK || rsp_status == ST_FULL)))
      else $error("enqueue result missing");

   a_move_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.mv_read || stat.mv_pending) |-> !req_ready)
      else $error("request taken during stack move");

endmodule
